// ===== src/windowed_value_count_fenwick_defines.svh =====
// ----------------------------------------------------------------------------
// windowed_value_count_fenwick_defines.svh
// Assertion macros shared by the windowed value count block.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_VALUE_COUNT_FENWICK_DEFINES_SVH
`define WINDOWED_VALUE_COUNT_FENWICK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define WVC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wvc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define WVC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wvc: next-cycle check failed");

`endif

// ===== src/wvc_pkg.sv =====
// ----------------------------------------------------------------------------
// wvc_pkg
// Shared types and constants of the windowed value count block.
// ----------------------------------------------------------------------------
package wvc_pkg;

    // Default sizes
    localparam int DEF_SEQ_DEPTH   = 65536;
    localparam int DEF_VALUE_LIMIT = 65535;

    // Element counts are held to 17 bits
    localparam int COUNT_W = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 17'd131071;

    localparam int REQ_W = 2;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req_type;

    // Tree walk kinds
    typedef enum logic {
        WALK_PREFIX = 1'b0,
        WALK_ADD    = 1'b1
    } t_walk_mode;

    // Which tree a walk touches
    typedef enum logic {
        TREE_COUNT = 1'b0,
        TREE_PRES  = 1'b1
    } t_tree_sel;

    // Sequencer to walk unit
    typedef struct packed {
        logic       go;
        t_walk_mode mode;
        t_tree_sel  sel;
        logic       dec;
    } t_walk_cmd;

    // Walk unit to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_walk_stat;

endpackage

// ===== src/wvc_if.sv =====
// ----------------------------------------------------------------------------
// wvc_if
// Request and response channels of the windowed value count block.
// ----------------------------------------------------------------------------
interface wvc_req_if import wvc_pkg::*; #(
    parameter int PW = 17,
    parameter int VW = 16
);
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [PW-1:0]    position;
    logic [VW-1:0]    item_value;
    logic [VW-1:0]    range_low;
    logic [VW-1:0]    range_high;

    modport source (
        output valid, req_type, position, item_value, range_low, range_high,
        input  ready
    );
    modport sink (
        input  valid, req_type, position, item_value, range_low, range_high,
        output ready
    );
endinterface

interface wvc_rsp_if #(
    parameter int CW = 17,
    parameter int VW = 16
);
    logic          valid;
    logic          ready;
    logic [CW-1:0] count_in_range;
    logic [VW-1:0] distinct_in_range;

    modport source (
        output valid, count_in_range, distinct_in_range,
        input  ready
    );
    modport sink (
        input  valid, count_in_range, distinct_in_range,
        output ready
    );
endinterface

// ===== src/wvc_ram.sv =====
// ----------------------------------------------------------------------------
// wvc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module wvc_ram #(
    parameter  int W     = 8,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/wvc_walker.sv =====
// ----------------------------------------------------------------------------
// wvc_walker
// Shared Fenwick walk unit: prefix sum (index down by lowest set bit) or
// point update (index up by lowest set bit, read-modify-write), one node
// per cycle on either tree.
// ----------------------------------------------------------------------------
`include "windowed_value_count_fenwick_defines.svh"

module wvc_walker import wvc_pkg::*; #(
    parameter  int VALUE_LIMIT = DEF_VALUE_LIMIT,
    parameter  int SW          = COUNT_W,
    localparam int VW          = $clog2(VALUE_LIMIT + 1),
    localparam int IW          = VW + 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_walk_cmd     i_cmd,
    input  logic [VW-1:0] i_index,
    output t_walk_stat    o_stat,
    output logic [SW-1:0] o_sum,
    output logic [VW-1:0] o_raddr,
    input  logic [SW-1:0] i_rdata_cnt,
    input  logic [SW-1:0] i_rdata_pres,
    output logic          o_we,
    output t_tree_sel     o_wsel,
    output logic [VW-1:0] o_waddr,
    output logic [SW-1:0] o_wdata
);

    logic          r_busy;
    logic          r_pend;
    t_walk_mode    r_mode;
    t_tree_sel     r_sel;
    logic          r_dec;
    logic [IW-1:0] r_idx;
    logic [VW-1:0] r_pend_idx;
    logic [SW-1:0] r_acc;

    logic [IW-1:0] lowbit;
    logic [IW-1:0] next_idx;
    logic          issue;
    logic          done;
    logic [SW-1:0] rdata;

    // Index step: lowest set bit off or on
    assign lowbit   = r_idx & (~r_idx + 1'b1);
    assign next_idx = (r_mode == WALK_PREFIX) ? (r_idx - lowbit) : (r_idx + lowbit);

    // A node is read while the index stays in the tree
    always_comb begin
        if (r_mode == WALK_PREFIX) begin
            issue = r_busy && (r_idx != '0);
        end else begin
            issue = r_busy && (r_idx != '0) && (r_idx <= IW'(VALUE_LIMIT));
        end
    end

    assign done  = r_busy && !issue && !r_pend;
    assign rdata = (r_sel == TREE_COUNT) ? i_rdata_cnt : i_rdata_pres;

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
        end else if (i_cmd.go) begin
            r_busy <= 1'b1;
            r_pend <= 1'b0;
        end else begin
            if (done) begin
                r_busy <= 1'b0;
            end
            r_pend <= issue;
        end
    end

    // Walk datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            r_mode <= i_cmd.mode;
            r_sel  <= i_cmd.sel;
            r_dec  <= i_cmd.dec;
            r_idx  <= IW'(i_index);
            r_acc  <= '0;
        end else begin
            if (issue) begin
                r_idx      <= next_idx;
                r_pend_idx <= r_idx[VW-1:0];
            end
            if (r_pend && (r_mode == WALK_PREFIX)) begin
                r_acc <= r_acc + rdata;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = done;
    assign o_sum       = r_acc;
    assign o_raddr     = r_idx[VW-1:0];
    assign o_we        = r_pend && (r_mode == WALK_ADD);
    assign o_wsel      = r_sel;
    assign o_waddr     = r_pend_idx;
    assign o_wdata     = r_dec ? (rdata - 1'b1) : (rdata + 1'b1);

    // Checks
    `WVC_ASSERT_IMP(a_go_when_idle, i_clk, i_rst_n, i_cmd.go, !r_busy)
    `WVC_ASSERT_IMP(a_add_no_raw, i_clk, i_rst_n, r_busy && (r_mode == WALK_ADD) && r_pend, r_idx > IW'(r_pend_idx))
    `WVC_ASSERT_IMP(a_prefix_down, i_clk, i_rst_n, r_busy && (r_mode == WALK_PREFIX) && r_pend, r_idx < IW'(r_pend_idx))

endmodule

// ===== src/windowed_value_count_fenwick.sv =====
// ----------------------------------------------------------------------------
// windowed_value_count_fenwick
// Window of sequence values with Fenwick count and presence trees.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per transaction: load a sequence entry, insert
//   or remove a position's value in the window, or query a value range.
//   o_rsp carries one transaction per query: element count and distinct
//   value count in the range. Load, insert and remove give no response.
//   i_req.ready is high only while the sequencer is idle; one request is
//   worked at a time. A single walk unit visits one tree node per cycle
//   through the tree memories' read port, VW = clog2(VALUE_LIMIT+1) nodes
//   at most per walk. A query takes four walks, none when the range is empty;
//   insert and remove take a fetch of the stored value plus two to four
//   walks, none when the stored value is out of range or the window is full.
//   After reset both trees are cleared, one entry per cycle, all
//   VALUE_LIMIT+1 entries (65536 by default), before the first request.
//   A query result waits in the output register while o_rsp is stalled;
//   the next request is still taken, and a following query holds its
//   result back until the register is free.
// ----------------------------------------------------------------------------
`include "windowed_value_count_fenwick_defines.svh"

module windowed_value_count_fenwick import wvc_pkg::*; #(
    parameter int SEQ_DEPTH   = DEF_SEQ_DEPTH,
    parameter int VALUE_LIMIT = DEF_VALUE_LIMIT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wvc_req_if.sink   i_req,
    wvc_rsp_if.source o_rsp
);

    localparam int VW  = $clog2(VALUE_LIMIT + 1);
    localparam int PW  = $clog2(SEQ_DEPTH + 1);
    localparam int SAW = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
    localparam int SW  = (VW > COUNT_W) ? VW : COUNT_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_CHECK,
        S_Q_CNT_HI,
        S_Q_CNT_LO,
        S_Q_PRS_HI,
        S_Q_PRS_LO,
        S_RESULT,
        S_U_HI,
        S_U_LO,
        S_U_CNT,
        S_U_PRS
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_go;
    logic             n_go;
    logic [VW-1:0]    r_clr_idx;
    t_req_type        r_req;
    logic [SAW-1:0]   r_seq_addr;
    logic [VW-1:0]    r_hi;
    logic [VW-1:0]    r_lo_m1;
    logic [VW-1:0]    r_val;
    logic [SW-1:0]    r_part;
    logic             r_vc_zero;
    logic             r_vc_one;
    logic [COUNT_W-1:0] r_cnt;
    logic [VW-1:0]    r_dist;
    logic [COUNT_W-1:0] r_total;
    logic             r_out_valid;
    logic [COUNT_W-1:0] r_out_cnt;
    logic [VW-1:0]    r_out_dist;

    logic             in_ready;
    logic             in_acc;
    t_req_type        in_req;
    logic             pos_ok;
    logic [VW-1:0]    lo_m1_in;
    logic [VW-1:0]    hi_in;
    logic             q_empty;
    logic             out_load;
    logic             clearing;
    logic [SW-1:0]    diff;
    logic             v_bad;

    logic [VW-1:0]    seq_rdata;
    logic             seq_we;
    logic [COUNT_W-1:0] cnt_rdata;
    logic [VW-1:0]    pres_rdata;
    logic             cnt_we;
    logic             pres_we;
    logic [VW-1:0]    tree_waddr;

    t_walk_cmd        w_cmd;
    t_walk_stat       w_stat;
    logic [VW-1:0]    w_index;
    logic [SW-1:0]    w_sum;
    logic [VW-1:0]    w_raddr;
    logic             w_we;
    t_tree_sel        w_wsel;
    logic [VW-1:0]    w_waddr;
    logic [SW-1:0]    w_wdata;

    // Request decode
    assign in_ready = (r_state == S_IDLE);
    assign in_acc   = i_req.valid && in_ready;
    assign in_req   = t_req_type'(i_req.req_type);
    assign pos_ok   = (i_req.position != '0) && (i_req.position <= PW'(SEQ_DEPTH));
    assign lo_m1_in = (i_req.range_low == '0) ? '0 : (i_req.range_low - 1'b1);
    assign hi_in    = (i_req.range_high > VW'(VALUE_LIMIT)) ? VW'(VALUE_LIMIT)
                                                            : i_req.range_high;
    assign q_empty  = (lo_m1_in >= hi_in);

    assign clearing = (r_state == S_CLEAR);
    assign out_load = (r_state == S_RESULT) && (!r_out_valid || o_rsp.ready);
    assign diff     = r_part - w_sum;
    assign v_bad    = (seq_rdata == '0) || (seq_rdata > VW'(VALUE_LIMIT)) ||
                      ((r_req == REQ_INSERT) && (r_total >= COUNT_MAX));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_idx == VW'(VALUE_LIMIT)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    case (in_req)
                        REQ_QUERY:  n_state = q_empty ? S_RESULT : S_Q_CNT_HI;
                        REQ_INSERT: n_state = pos_ok ? S_FETCH : S_IDLE;
                        REQ_REMOVE: n_state = pos_ok ? S_FETCH : S_IDLE;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_FETCH: n_state = S_CHECK;
            S_CHECK: n_state = v_bad ? S_IDLE : S_U_HI;
            S_Q_CNT_HI: if (w_stat.done) n_state = S_Q_CNT_LO;
            S_Q_CNT_LO: if (w_stat.done) n_state = S_Q_PRS_HI;
            S_Q_PRS_HI: if (w_stat.done) n_state = S_Q_PRS_LO;
            S_Q_PRS_LO: if (w_stat.done) n_state = S_RESULT;
            S_RESULT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            S_U_HI: if (w_stat.done) n_state = S_U_LO;
            S_U_LO: begin
                if (w_stat.done) begin
                    n_state = ((r_req == REQ_REMOVE) && (diff == '0)) ? S_IDLE : S_U_CNT;
                end
            end
            S_U_CNT: begin
                if (w_stat.done) begin
                    if (((r_req == REQ_INSERT) && r_vc_zero) ||
                        ((r_req == REQ_REMOVE) && r_vc_one)) begin
                        n_state = S_U_PRS;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_U_PRS: if (w_stat.done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Start a walk on entry to each walk state
    always_comb begin
        case (n_state)
            S_Q_CNT_HI, S_Q_CNT_LO, S_Q_PRS_HI, S_Q_PRS_LO,
            S_U_HI, S_U_LO, S_U_CNT, S_U_PRS: n_go = (n_state != r_state);
            default:                          n_go = 1'b0;
        endcase
    end

    // State, sequencer registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_go        <= 1'b0;
            r_clr_idx   <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= n_go;

            if (clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end

            // Latch the request
            if (in_acc) begin
                r_req      <= in_req;
                r_seq_addr <= SAW'(i_req.position - 1'b1);
                r_hi       <= hi_in;
                r_lo_m1    <= lo_m1_in;
                r_cnt      <= '0;
                r_dist     <= '0;
            end

            if ((r_state == S_CHECK) && !v_bad) begin
                r_val <= seq_rdata;
            end

            // Collect walk results
            if (w_stat.done) begin
                case (r_state)
                    S_Q_CNT_HI, S_Q_PRS_HI, S_U_HI: r_part <= w_sum;
                    S_Q_CNT_LO: r_cnt  <= COUNT_W'(diff);
                    S_Q_PRS_LO: r_dist <= VW'(diff);
                    S_U_LO: begin
                        r_vc_zero <= (diff == '0);
                        r_vc_one  <= (diff == SW'(1));
                        if (r_req == REQ_INSERT) begin
                            r_total <= r_total + 1'b1;
                        end else if (diff != '0) begin
                            r_total <= r_total - 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            // Output register
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_cnt   <= r_cnt;
                r_out_dist  <= r_dist;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk command
    always_comb begin
        w_cmd.go   = r_go;
        w_cmd.mode = ((r_state == S_U_CNT) || (r_state == S_U_PRS)) ? WALK_ADD : WALK_PREFIX;
        w_cmd.sel  = ((r_state == S_Q_PRS_HI) || (r_state == S_Q_PRS_LO) ||
                      (r_state == S_U_PRS)) ? TREE_PRES : TREE_COUNT;
        w_cmd.dec  = (r_req == REQ_REMOVE);
        case (r_state)
            S_Q_CNT_HI, S_Q_PRS_HI: w_index = r_hi;
            S_Q_CNT_LO, S_Q_PRS_LO: w_index = r_lo_m1;
            S_U_LO:                 w_index = r_val - 1'b1;
            default:                w_index = r_val;
        endcase
    end

    wvc_walker #(
        .VALUE_LIMIT (VALUE_LIMIT),
        .SW          (SW)
    ) u_walker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_index      (w_index),
        .o_stat       (w_stat),
        .o_sum        (w_sum),
        .o_raddr      (w_raddr),
        .i_rdata_cnt  (SW'(cnt_rdata)),
        .i_rdata_pres (SW'(pres_rdata)),
        .o_we         (w_we),
        .o_wsel       (w_wsel),
        .o_waddr      (w_waddr),
        .o_wdata      (w_wdata)
    );

    // Sequence store
    assign seq_we = in_acc && (in_req == REQ_LOAD) && pos_ok;

    wvc_ram #(
        .W     (VW),
        .DEPTH (SEQ_DEPTH)
    ) u_seq_ram (
        .i_clk   (i_clk),
        .i_we    (seq_we),
        .i_waddr (SAW'(i_req.position - 1'b1)),
        .i_wdata (i_req.item_value),
        .i_raddr (r_seq_addr),
        .o_rdata (seq_rdata)
    );

    // Tree memories: clearing sweep after reset, then walk writes
    assign cnt_we     = clearing || (w_we && (w_wsel == TREE_COUNT));
    assign pres_we    = clearing || (w_we && (w_wsel == TREE_PRES));
    assign tree_waddr = clearing ? r_clr_idx : w_waddr;

    wvc_ram #(
        .W     (COUNT_W),
        .DEPTH (VALUE_LIMIT + 1)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (tree_waddr),
        .i_wdata (clearing ? '0 : COUNT_W'(w_wdata)),
        .i_raddr (w_raddr),
        .o_rdata (cnt_rdata)
    );

    wvc_ram #(
        .W     (VW),
        .DEPTH (VALUE_LIMIT + 1)
    ) u_pres_ram (
        .i_clk   (i_clk),
        .i_we    (pres_we),
        .i_waddr (tree_waddr),
        .i_wdata (clearing ? '0 : VW'(w_wdata)),
        .i_raddr (w_raddr),
        .o_rdata (pres_rdata)
    );

    // Ports
    assign i_req.ready             = in_ready;
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.count_in_range    = r_out_cnt;
    assign o_rsp.distinct_in_range = r_out_dist;

    // Checks
    `WVC_ASSERT_IMP(a_ready_when_idle, i_clk, i_rst_n, in_ready, !w_stat.busy && !r_go)
    `WVC_ASSERT_IMP(a_total_bound, i_clk, i_rst_n, 1'b1, r_total <= COUNT_MAX)
    `WVC_ASSERT_IMP(a_clear_excl, i_clk, i_rst_n, clearing, !w_we && !w_stat.busy)
    `WVC_ASSERT_NXT(a_go_starts_walk, i_clk, i_rst_n, r_go, w_stat.busy)

endmodule

// ===== bench/windowed_value_count_fenwick_test.sv =====
// ----------------------------------------------------------------------------
// windowed_value_count_fenwick_test
// Self-checking bench for the windowed value count block. A scoreboard class
// keeps its own sequence store and Fenwick count and presence trees. It works
// out the tally of every query as the request transaction is accepted, and
// checks each response transaction against the oldest tally still due.
// Stimulus is a short directed run over the corner cases, then random
// load/insert/remove/query traffic on a small position and value pool.
// Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module windowed_value_count_fenwick_test;
    import wvc_pkg::*;

    localparam int SEQ_DEPTH    = DEF_SEQ_DEPTH;
    localparam int VLIM         = DEF_VALUE_LIMIT;
    localparam int RANDOM_ITEMS = 976;
    localparam int HOLD_ITEM    = 300;   // receiver holds off here
    localparam int PAUSE_ITEM   = 650;   // sender waits for every tally here
    localparam int CALM_ITEM    = 830;   // no idling from here on
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_QUERIES = 6;
    localparam int DRAIN_CYCLES = 200;
    // Clearing pass after reset is quiet on both channels; the limit allows for it several times over
    localparam int STALL_LIMIT  = 4 * (VLIM + 1);

    typedef struct {
        t_req_type kind;
        bit [16:0] position;
        bit [15:0] item_value;
        bit [15:0] range_low;
        bit [15:0] range_high;
    } t_request;

    typedef struct {
        bit [16:0] count;
        bit [15:0] distinct;
    } t_tally;

    // ------------------------------------------------------------------------
    // Scoreboard: window predictor and queue of tallies still due
    // ------------------------------------------------------------------------
    class window_scoreboard;
        bit [15:0]   seq_val [SEQ_DEPTH];
        int unsigned node [2][VLIM+1];
        t_tally      due_tallies [$];
        int          failures;

        function int unsigned prefix(t_tree_sel sel, int unsigned v);
            int unsigned acc;
            int unsigned i;
            acc = 0;
            i = (v > VLIM) ? VLIM : v;
            while (i != 0) begin
                acc += node[sel][i];
                i -= i & (~i + 1);
            end
            return acc;
        endfunction

        function void bump(t_tree_sel sel, int unsigned v, int unsigned delta);
            int unsigned i;
            i = v;
            while (i >= 1 && i <= VLIM) begin
                node[sel][i] += delta;
                i += i & (~i + 1);
            end
        endfunction

        function int unsigned occurrences(int unsigned v);
            return prefix(TREE_COUNT, v) - prefix(TREE_COUNT, v - 1);
        endfunction

        function int pending();
            return due_tallies.size();
        endfunction

        // Apply one accepted request transaction to the predicted state
        function void note_request(t_request r);
            int unsigned lo;
            int unsigned hi;
            int unsigned v;
            t_tally      t;
            if (r.kind == REQ_QUERY) begin
                lo = (r.range_low == 0) ? 1 : 32'(r.range_low);
                hi = (r.range_high > VLIM) ? VLIM : 32'(r.range_high);
                t.count    = '0;
                t.distinct = '0;
                if (lo <= hi) begin
                    t.count    = 17'(prefix(TREE_COUNT, hi) - prefix(TREE_COUNT, lo - 1));
                    t.distinct = 16'(prefix(TREE_PRES, hi) - prefix(TREE_PRES, lo - 1));
                end
                due_tallies.push_back(t);
                return;
            end
            // out-of-range position: nothing happens
            if (r.position == 0 || r.position > SEQ_DEPTH)
                return;
            if (r.kind == REQ_LOAD) begin
                seq_val[r.position - 1] = r.item_value;
                return;
            end
            v = 32'(seq_val[r.position - 1]);
            if (v == 0 || v > VLIM)
                return;
            if (r.kind == REQ_INSERT) begin
                // full window refuses further elements
                if (prefix(TREE_COUNT, VLIM) >= COUNT_MAX)
                    return;
                bump(TREE_COUNT, v, 1);
                if (occurrences(v) == 1)
                    bump(TREE_PRES, v, 1);
            end else begin
                // removal of an absent value is ignored
                if (occurrences(v) == 0)
                    return;
                bump(TREE_COUNT, v, 32'hFFFF_FFFF);
                if (occurrences(v) == 0)
                    bump(TREE_PRES, v, 32'hFFFF_FFFF);
            end
        endfunction

        task report(string msg);
            failures++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Compare one accepted response transaction with the oldest tally
        task check_result(bit [16:0] count, bit [15:0] distinct);
            t_tally t;
            if (due_tallies.size() == 0) begin
                report($sformatf("response %0d/%0d with no query outstanding",
                                 count, distinct));
                return;
            end
            t = due_tallies.pop_front();
            if (count !== t.count)
                report($sformatf("count_in_range %0d, expected %0d", count, t.count));
            if (distinct !== t.distinct)
                report($sformatf("distinct_in_range %0d, expected %0d",
                                 distinct, t.distinct));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   calm;
    bit   hold_rx;
    int   stall_cycles;
    bit   loaded [1:SEQ_DEPTH];
    int   loaded_pos [$];

    window_scoreboard board = new();

    wvc_req_if #(.PW(17), .VW(16)) req_ch ();
    wvc_rsp_if #(.CW(17), .VW(16)) rsp_ch ();

    windowed_value_count_fenwick dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Request construction
    // ------------------------------------------------------------------------
    // Unused fields carry random bits so that every bit toggles
    function automatic t_request blank_req(t_req_type kind);
        t_request r;
        r.kind       = kind;
        r.position   = 17'($urandom);
        r.item_value = 16'($urandom);
        r.range_low  = 16'($urandom);
        r.range_high = 16'($urandom);
        return r;
    endfunction

    function automatic t_request load_req(int pos, int val);
        t_request r;
        r = blank_req(REQ_LOAD);
        r.position   = 17'(pos);
        r.item_value = 16'(val);
        return r;
    endfunction

    function automatic t_request move_req(t_req_type kind, int pos);
        t_request r;
        r = blank_req(kind);
        r.position = 17'(pos);
        return r;
    endfunction

    function automatic t_request query_req(int lo, int hi);
        t_request r;
        r = blank_req(REQ_QUERY);
        r.range_low  = 16'(lo);
        r.range_high = 16'(hi);
        return r;
    endfunction

    function automatic int bad_position();
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(SEQ_DEPTH + 1, 131071);
    endfunction

    function automatic t_request random_query();
        int lo;
        int hi;
        case ($urandom_range(0, 9))
            0: begin lo = 0; hi = VLIM; end
            1: begin lo = $urandom_range(2, VLIM); hi = $urandom_range(1, lo - 1); end
            2: begin lo = $urandom_range(0, 65535); hi = $urandom_range(0, 65535); end
            3: begin lo = $urandom_range(65500, VLIM); hi = $urandom_range(lo, VLIM); end
            4: begin lo = 0; hi = $urandom_range(0, 30); end
            default: begin lo = $urandom_range(1, 24); hi = $urandom_range(lo, 30); end
        endcase
        return query_req(lo, hi);
    endfunction

    // Mostly well-formed traffic on a small pool so values repeat in the window
    function automatic t_request random_request();
        int pick;
        int pos;
        int val;
        pick = (loaded_pos.size() == 0) ? 0 : $urandom_range(0, 99);
        if (pick < 15) begin
            case ($urandom_range(0, 19))
                0:       pos = bad_position();
                1:       pos = $urandom_range(1, SEQ_DEPTH);
                2:       pos = SEQ_DEPTH;
                default: pos = $urandom_range(1, 48);
            endcase
            case ($urandom_range(0, 19))
                0:       val = 0;
                1:       val = VLIM;
                2:       val = $urandom_range(65512, VLIM);
                3:       val = $urandom_range(0, 65535);
                default: val = $urandom_range(1, 24);
            endcase
            return load_req(pos, val);
        end
        if (pick < 68) begin
            // never touch a valid position that was not loaded
            if ($urandom_range(0, 19) == 0)
                pos = bad_position();
            else
                pos = loaded_pos[$urandom_range(0, loaded_pos.size() - 1)];
            return move_req((pick < 50) ? REQ_INSERT : REQ_REMOVE, pos);
        end
        return random_query();
    endfunction

    // ------------------------------------------------------------------------
    // Request driver: called at a falling edge, returns at a falling edge
    // ------------------------------------------------------------------------
    task automatic issue(input t_request r);
        if (!calm && $urandom_range(0, 9) == 0) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        req_ch.req_type   = r.kind;
        req_ch.position   = r.position;
        req_ch.item_value = r.item_value;
        req_ch.range_low  = r.range_low;
        req_ch.range_high = r.range_high;
        req_ch.valid      = 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        board.note_request(r);
        if (r.kind == REQ_LOAD && r.position >= 1 && r.position <= SEQ_DEPTH
                && !loaded[r.position]) begin
            loaded[r.position] = 1'b1;
            loaded_pos.push_back(32'(r.position));
        end
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Response side: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_rx = 1'b0;
                rsp_ch.ready = 1'b1;
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 19) - 1) @(negedge i_clk);
            end else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // Response check at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.count_in_range, rsp_ch.distinct_in_range);
    end

    // Cycles without any transaction on either channel
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Watchdog
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("timeout after %0d quiet cycles", STALL_LIMIT);
        $display("windowed_value_count_fenwick verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        calm              = 1'b0;
        hold_rx           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_LOAD;
        req_ch.position   = '0;
        req_ch.item_value = '0;
        req_ch.range_low  = '0;
        req_ch.range_high = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty window, bounds, bad positions, zero value,
        // duplicates, absent removal, overwrite of an entry in the window
        issue(query_req(0, VLIM));
        issue(load_req(1, 1));
        issue(load_req(SEQ_DEPTH, VLIM));
        issue(load_req(2, 1));
        issue(load_req(3, 0));
        issue(load_req(0, 5));
        issue(load_req(131071, 7));
        issue(move_req(REQ_INSERT, 1));
        issue(move_req(REQ_INSERT, SEQ_DEPTH));
        issue(move_req(REQ_INSERT, 2));
        issue(move_req(REQ_INSERT, 3));
        issue(move_req(REQ_INSERT, 0));
        issue(move_req(REQ_INSERT, SEQ_DEPTH + 1));
        issue(query_req(1, VLIM));
        issue(query_req(1, 1));
        issue(query_req(VLIM, VLIM));
        issue(query_req(5, 4));
        issue(query_req(0, 0));
        issue(move_req(REQ_REMOVE, 2));
        issue(move_req(REQ_REMOVE, 1));
        issue(move_req(REQ_REMOVE, 1));
        issue(move_req(REQ_REMOVE, 3));
        issue(load_req(SEQ_DEPTH, 32768));
        issue(move_req(REQ_REMOVE, SEQ_DEPTH));
        issue(query_req(0, 65535));

        // Random traffic
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_ITEM) begin
                // queries pile up behind a stalled response channel
                hold_rx = 1'b1;
                for (int q = 0; q < HOLD_QUERIES; q++)
                    issue(random_query());
            end
            if (n == PAUSE_ITEM) begin
                req_ch.valid = 1'b0;
                while (board.pending() != 0) @(posedge i_clk);
                @(negedge i_clk);
            end
            if (n == CALM_ITEM)
                calm = 1'b1;
            issue(random_request());
        end
        req_ch.valid = 1'b0;

        // Drain
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (board.failures == 0 && board.pending() == 0)
            $display("windowed_value_count_fenwick verification clean");
        else
            $display("windowed_value_count_fenwick verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/wvc_pkg.sv
src/wvc_if.sv
src/wvc_ram.sv
src/wvc_walker.sv
src/windowed_value_count_fenwick.sv
bench/windowed_value_count_fenwick_test.sv
